>>> design/fdc_pkg.sv
package fdc_pkg;

    // Fixed field widths of the item formats
    localparam int ACTION_W      = 3;
    localparam int FEAT_IDX_W    = 6;
    localparam int VALUE_IDX_W   = 8;

    // Default sizing of the feature file
    localparam int FEATURE_COUNT_DEF = 64;
    localparam int VALUE_MAX_DEF     = 255;

    // Decoded flag operations
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_POS_SET  = 3'd1,
        ACT_NEG_SET  = 3'd2,
        ACT_REQUIRE  = 3'd3,
        ACT_DISALLOW = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_UNIFY    = 3'd6
    } t_action;

    // Control from the pipeline to the feature file
    typedef struct packed {
        logic fire;       // stage-1 item completes this cycle
        logic clear_all;  // item starts a new string
        logic wr_en;      // operation writes its feature
    } t_ff_ctrl;

    // Outcome of one operation
    typedef struct packed {
        logic passed;
        logic wr_en;
    } t_op_status;

endpackage

>>> design/fdc_if.sv
// Input item channel
interface fdc_in_if import fdc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [FEAT_IDX_W-1:0]  feature_index;
    logic [VALUE_IDX_W-1:0] value_index;
    logic                   first;
    logic                   last;

    modport source (output valid, action, feature_index, value_index, first, last,
                    input ready);
    modport sink   (input valid, action, feature_index, value_index, first, last,
                    output ready);
endinterface

// Result channel
interface fdc_out_if;
    logic valid;
    logic ready;
    logic op_passed;
    logic string_valid;
    logic end_of_string;

    modport source (output valid, op_passed, string_valid, end_of_string, input ready);
    modport sink   (input valid, op_passed, string_valid, end_of_string, output ready);
endinterface

>>> design/fdc_feature_file.sv
module fdc_feature_file import fdc_pkg::*; #(
    parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
    parameter int VALUE_MAX     = VALUE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [FEAT_IDX_W-1:0]         i_rd_idx,
    input  t_ff_ctrl                      i_ctrl,
    input  logic signed [$clog2(VALUE_MAX+1):0] i_wr_data,
    output logic signed [$clog2(VALUE_MAX+1):0] o_rd_value
);

    localparam int FV_W  = $clog2(VALUE_MAX + 1) + 1;
    localparam int FC_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    logic signed [FV_W-1:0]  r_mem [FEATURE_COUNT];
    logic signed [FV_W-1:0]  r_rdata;
    logic [FC_AW-1:0]        r_addr;
    logic                    r_inrange;
    logic [FEATURE_COUNT-1:0] r_valid;
    logic [FEATURE_COUNT-1:0] n_valid;
    logic                    r_fwd_vld;
    logic [FC_AW-1:0]        r_fwd_addr;
    logic signed [FV_W-1:0]  r_fwd_data;
    logic [FC_AW-1:0]        w_rd_addr;
    logic                    w_rd_inrange;
    logic                    w_wr;
    logic                    w_hit;

    assign w_rd_addr    = FC_AW'(i_rd_idx);
    assign w_rd_inrange = (32'(i_rd_idx) < 32'(FEATURE_COUNT));
    assign w_wr         = i_ctrl.fire && i_ctrl.wr_en && r_inrange;

    // Memory: registered read on acceptance, write when the stage-1 item completes
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata   <= r_mem[w_rd_addr];
            r_addr    <= w_rd_addr;
            r_inrange <= w_rd_inrange;
        end
        if (w_wr) begin
            r_mem[r_addr] <= i_wr_data;
        end
    end

    // Valid bits: a new string wipes them all at once
    always_comb begin
        n_valid = i_ctrl.clear_all ? '0 : r_valid;
        if (w_wr) begin
            n_valid[r_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.fire) begin
            r_valid <= n_valid;
        end
    end

    // Last write, to cover a read issued on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (w_wr) begin
            r_fwd_vld <= 1'b1;
        end else if (i_ctrl.fire && i_ctrl.clear_all) begin
            r_fwd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fwd_addr <= r_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    // Resolved value for the stage-1 item; unwritten or out of range reads zero
    assign w_hit = r_fwd_vld && (r_fwd_addr == r_addr);

    always_comb begin
        if (!r_inrange) begin
            o_rd_value = '0;
        end else if (w_hit) begin
            o_rd_value = r_fwd_data;
        end else if (r_valid[r_addr]) begin
            o_rd_value = r_rdata;
        end else begin
            o_rd_value = '0;
        end
    end

    // Bypass entry always belongs to a live feature
    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> r_valid[r_fwd_addr])
        else $error("bypass entry points at a cleared feature");

endmodule

>>> design/fdc_op_eval.sv
module fdc_op_eval import fdc_pkg::*; #(
    parameter int VALUE_MAX = VALUE_MAX_DEF
) (
    input  logic [ACTION_W-1:0]                 i_action,
    input  logic [VALUE_IDX_W-1:0]              i_value_index,
    input  logic signed [$clog2(VALUE_MAX+1):0] i_feature_value,
    output t_op_status                          o_status,
    output logic signed [$clog2(VALUE_MAX+1):0] o_wr_data
);

    localparam int VAL_W = $clog2(VALUE_MAX + 1);
    localparam int FV_W  = VAL_W + 1;

    logic [VAL_W-1:0]       w_n;
    logic signed [FV_W-1:0] w_n_s;
    logic signed [FV_W-1:0] w_v;
    logic signed [FV_W-1:0] w_neg_v;
    logic                   w_n_zero;
    logic                   w_v_zero;
    logic                   w_v_eq_n;
    logic                   w_unify_ok;

    // Saturate the value number
    assign w_n = (32'(i_value_index) > 32'(VALUE_MAX)) ? VAL_W'(VALUE_MAX)
                                                        : VAL_W'(i_value_index);
    assign w_n_s    = signed'({1'b0, w_n});
    assign w_v      = i_feature_value;
    assign w_neg_v  = -w_v;
    assign w_n_zero = (w_n == '0);
    assign w_v_zero = (w_v == '0);
    assign w_v_eq_n = (w_v == w_n_s);
    assign w_unify_ok = w_v_zero || w_v_eq_n || (w_v[FV_W-1] && (w_neg_v != w_n_s));

    // Operation decode
    always_comb begin
        o_status.passed = 1'b1;
        o_status.wr_en  = 1'b0;
        o_wr_data       = w_n_s;
        unique case (t_action'(i_action))
            ACT_POS_SET: begin
                o_status.wr_en = 1'b1;
            end
            ACT_NEG_SET: begin
                o_status.wr_en = 1'b1;
                o_wr_data      = -w_n_s;
            end
            ACT_REQUIRE: begin
                o_status.passed = w_n_zero ? !w_v_zero : w_v_eq_n;
            end
            ACT_DISALLOW: begin
                o_status.passed = w_n_zero ? w_v_zero : !w_v_eq_n;
            end
            ACT_CLEAR: begin
                o_status.wr_en = 1'b1;
                o_wr_data      = '0;
            end
            ACT_UNIFY: begin
                o_status.passed = w_unify_ok;
                o_status.wr_en  = w_unify_ok;
            end
            default: begin
                o_status.passed = 1'b1;
            end
        endcase
    end

endmodule

>>> design/flag_diacritic_checker_top.sv
// Flag diacritic checker. Takes one decoded flag operation per transfer and
// returns one result per item: whether the operation passed, the running
// verdict of the string (low from the first failure until the next item
// with first set) and a copy of last. Sustained rate is one item per clock
// while results are taken. In the single read-modify-write of the feature
// file the registered memory read is issued in the accept cycle; the
// operation is evaluated and written back as the stage-1 item moves on to
// the result register, with a bypass for back-to-back access to one feature.
// Reset and a first item clear the whole feature file at once through
// per-feature valid bits; no clearing pass is needed. Feature indices of
// FEATURE_COUNT or above read as zero and are never written; value numbers
// above VALUE_MAX saturate.
module flag_diacritic_checker_top import fdc_pkg::*; #(
    parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
    parameter int VALUE_MAX     = VALUE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdc_in_if.sink     i_in,
    fdc_out_if.source  o_out
);

    localparam int FV_W = $clog2(VALUE_MAX + 1) + 1;

    logic                   r_s1_vld;
    logic [ACTION_W-1:0]    r_s1_action;
    logic [VALUE_IDX_W-1:0] r_s1_value;
    logic                   r_s1_first;
    logic                   r_s1_last;
    logic                   r_failed;
    logic                   n_failed;
    logic                   r_out_vld;
    logic                   r_out_passed;
    logic                   r_out_string_valid;
    logic                   r_out_eos;
    logic                   w_in_xfer;
    logic                   w_s1_fire;
    logic signed [FV_W-1:0] w_feature_value;
    logic signed [FV_W-1:0] w_wr_data;
    t_op_status             w_status;
    t_ff_ctrl               w_ctrl;

    // Handshake: stage 1 moves on when the result register is free or its result is taken
    assign w_s1_fire  = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || w_s1_fire;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // Stage 1 item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_action <= i_in.action;
            r_s1_value  <= i_in.value_index;
            r_s1_first  <= i_in.first;
            r_s1_last   <= i_in.last;
        end
    end

    assign w_ctrl.fire      = w_s1_fire;
    assign w_ctrl.clear_all = r_s1_first;
    assign w_ctrl.wr_en     = w_status.wr_en;

    fdc_feature_file #(
        .FEATURE_COUNT (FEATURE_COUNT),
        .VALUE_MAX     (VALUE_MAX)
    ) u_file (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_xfer),
        .i_rd_idx   (i_in.feature_index),
        .i_ctrl     (w_ctrl),
        .i_wr_data  (w_wr_data),
        .o_rd_value (w_feature_value)
    );

    // A first item sees an all-zero file
    fdc_op_eval #(
        .VALUE_MAX (VALUE_MAX)
    ) u_eval (
        .i_action        (r_s1_action),
        .i_value_index   (r_s1_value),
        .i_feature_value (r_s1_first ? '0 : w_feature_value),
        .o_status        (w_status),
        .o_wr_data       (w_wr_data)
    );

    // Sticky failure of the current string
    assign n_failed = (r_s1_first ? 1'b0 : r_failed) || !w_status.passed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b0;
        end else if (w_s1_fire) begin
            r_failed <= n_failed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_passed       <= w_status.passed;
            r_out_string_valid <= !n_failed;
            r_out_eos          <= r_s1_last;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.op_passed     = r_out_passed;
    assign o_out.string_valid  = r_out_string_valid;
    assign o_out.end_of_string = r_out_eos;

    // Reported verdict tracks the sticky failure bit
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire |=> (r_failed == !r_out_string_valid))
        else $error("string verdict disagrees with failure state");

    // Unconditional operations always pass
    a_uncond_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && (r_s1_action == ACT_NONE || r_s1_action == ACT_POS_SET ||
                      r_s1_action == ACT_NEG_SET || r_s1_action == ACT_CLEAR)
        |=> r_out_passed)
        else $error("unconditional operation reported as failed");

    // A held stage-1 item is never overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_s1_fire |-> !i_in.ready)
        else $error("input accepted over a stalled item");

endmodule

>>> test/tb.sv
module tb;
    import fdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code outside the decoded set; behaves as no operation
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 3'd7;

    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES       = 8;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic op_passed;
        logic string_valid;
        logic end_of_string;
    } t_verdict;

    // Predicts the verdict of every accepted symbol and checks the results in order
    class flag_scoreboard;
        bit signed [8:0] feature_val [FEATURE_COUNT_DEF];
        bit              string_failed;
        t_verdict        pending_verdicts [$];
        int              errors;

        function void clear_features();
            foreach (feature_val[i]) feature_val[i] = '0;
            string_failed = 1'b0;
        endfunction

        function void predict_item(logic [ACTION_W-1:0] act, logic [FEAT_IDX_W-1:0] fi,
                                   logic [VALUE_IDX_W-1:0] vi, logic fst, logic lst);
            int       v;
            int       n;
            bit       ok;
            bit       wr;
            t_verdict exp_v;
            n = (vi > VALUE_MAX_DEF) ? VALUE_MAX_DEF : int'(vi);
            if (fst)
                clear_features();
            v  = (fi < FEATURE_COUNT_DEF) ? int'(feature_val[fi]) : 0;
            ok = 1'b1;
            wr = 1'b0;
            case (t_action'(act))
                ACT_POS_SET: wr = 1'b1;
                ACT_NEG_SET: begin
                    wr = 1'b1;
                    n  = -n;
                end
                ACT_REQUIRE:  ok = (n == 0) ? (v != 0) : (v == n);
                ACT_DISALLOW: ok = (n == 0) ? (v == 0) : (v != n);
                ACT_CLEAR: begin
                    wr = 1'b1;
                    n  = 0;
                end
                ACT_UNIFY: begin
                    ok = (v == 0) || (v == n) || (v < 0 && -v != n);
                    wr = ok;
                end
                default: ok = 1'b1;
            endcase
            // writes beyond the file are dropped
            if (wr && fi < FEATURE_COUNT_DEF)
                feature_val[fi] = 9'(n);
            if (!ok)
                string_failed = 1'b1;
            exp_v.op_passed     = ok;
            exp_v.string_valid  = !string_failed;
            exp_v.end_of_string = lst;
            pending_verdicts.push_back(exp_v);
        endfunction

        function void check_verdict(logic passed, logic str_valid, logic eos);
            t_verdict exp_v;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing outstanding, %s %b %b %b",
                         $time, "op_passed/string_valid/end_of_string",
                         passed, str_valid, eos);
                errors++;
                return;
            end
            exp_v = pending_verdicts.pop_front();
            if (passed !== exp_v.op_passed) begin
                $display("%0t: op_passed expected %b actual %b", $time, exp_v.op_passed, passed);
                errors++;
            end
            if (str_valid !== exp_v.string_valid) begin
                $display("%0t: string_valid expected %b actual %b",
                         $time, exp_v.string_valid, str_valid);
                errors++;
            end
            if (eos !== exp_v.end_of_string) begin
                $display("%0t: end_of_string expected %b actual %b",
                         $time, exp_v.end_of_string, eos);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fdc_in_if  in_ch ();
    fdc_out_if out_ch ();

    flag_diacritic_checker_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    flag_scoreboard board;
    int             items_sent;
    int             idle_cycles;
    bit             tx_calm;
    bit             rx_calm;
    bit             rx_hold_req;

    // Clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Offer one symbol after a random gap (none when calm) and wait for its transfer
    task automatic put(input logic [ACTION_W-1:0] act, input logic [FEAT_IDX_W-1:0] fi,
                       input logic [VALUE_IDX_W-1:0] vi, input logic fst, input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.feature_index <= fi;
        in_ch.value_index   <= vi;
        in_ch.first         <= fst;
        in_ch.last          <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Well-formed string: first on the opening symbol, last on the closing one.
    // Features and values mostly from a small pool so that tests hit stored values.
    task automatic send_string();
        int                     len;
        logic [ACTION_W-1:0]    act;
        logic [FEAT_IDX_W-1:0]  fi;
        logic [VALUE_IDX_W-1:0] vi;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            act = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(ACT_POS_SET, ACT_UNIFY));
            fi  = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
            vi  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            put(act, fi, vi, k == 0, k == len - 1);
        end
    endtask

    // Stop offering and wait until every predicted verdict has come back;
    // the monitor first notes the last transfer
    task automatic wait_for_verdicts();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Transfer monitor and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                board.predict_item(in_ch.action, in_ch.feature_index, in_ch.value_index,
                                   in_ch.first, in_ch.last);
            if (out_ch.valid && out_ch.ready)
                board.check_verdict(out_ch.op_passed, out_ch.string_valid,
                                    out_ch.end_of_string);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, calm stretches and one long hold-off
    initial begin
        int stall;
        int served;
        served = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req   = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = rx_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            served++;
            if (served % 64 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Stimulus
    initial begin
        int target;
        board = new;
        board.clear_features();
        items_sent          = 0;
        idle_cycles         = 0;
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        rx_hold_req         = 1'b0;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_NONE;
        in_ch.feature_index = '0;
        in_ch.value_index   = '0;
        in_ch.first         = 1'b0;
        in_ch.last          = 1'b0;
        out_ch.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, field extremes, failure stickiness
        put(ACT_POS_SET,  6'd0,  8'd255, 1'b1, 1'b0);
        put(ACT_REQUIRE,  6'd0,  8'd255, 1'b0, 1'b0);
        put(ACT_REQUIRE,  6'd0,  8'd0,   1'b0, 1'b0);
        put(ACT_DISALLOW, 6'd0,  8'd255, 1'b0, 1'b0);   // fails the string
        put(ACT_NEG_SET,  6'd63, 8'd255, 1'b0, 1'b0);
        put(ACT_UNIFY,    6'd63, 8'd1,   1'b0, 1'b0);   // negative, other value: passes
        put(ACT_UNIFY,    6'd63, 8'd2,   1'b0, 1'b0);   // clash: fails, no write
        put(ACT_UNIFY,    6'd63, 8'd1,   1'b0, 1'b0);
        put(ACT_DISALLOW, 6'd5,  8'd0,   1'b0, 1'b0);
        put(ACT_CLEAR,    6'd63, 8'd0,   1'b0, 1'b0);
        put(ACT_REQUIRE,  6'd63, 8'd0,   1'b0, 1'b0);
        put(ACT_NONE,     6'd10, 8'd7,   1'b0, 1'b1);
        // last with no following first: state carries on
        put(ACT_RESERVED, 6'd0,  8'd0,   1'b0, 1'b0);
        put(ACT_REQUIRE,  6'd0,  8'd255, 1'b0, 1'b0);
        // first clears the file before its own operation
        put(ACT_REQUIRE,  6'd0,  8'd0,   1'b1, 1'b1);
        put(ACT_UNIFY,    6'd0,  8'd0,   1'b1, 1'b0);
        put(ACT_NEG_SET,  6'd1,  8'd0,   1'b0, 1'b0);
        put(ACT_UNIFY,    6'd1,  8'd255, 1'b0, 1'b0);
        put(ACT_DISALLOW, 6'd1,  8'd3,   1'b0, 1'b1);
        put(ACT_POS_SET,  6'd63, 8'd128, 1'b1, 1'b1);
        // negated value unified with its own magnitude fails
        put(ACT_NEG_SET,  6'd2,  8'd9,   1'b1, 1'b0);
        put(ACT_UNIFY,    6'd2,  8'd9,   1'b0, 1'b0);
        put(ACT_REQUIRE,  6'd2,  8'd9,   1'b0, 1'b1);

        // Random phases: mostly well-formed strings, some raw noise
        items_sent = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            tx_calm = (ph % 3 == 1);
            if (ph == 2) begin
                rx_hold_req = 1'b1;
                tx_calm     = 1'b1;
            end
            if (ph == 5)
                wait_for_verdicts();
            target = (ph + 1) * RANDOM_ITEMS / PHASES;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 8)
                    send_string();
                else
                    put(3'($urandom), 6'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end

        wait_for_verdicts();
        repeat (SETTLE) @(posedge i_clk);
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
